// ----- src/mi3_pkg.sv -----
// Package for the 3x3 fixed-point matrix inverse: transaction types and constants.
// Used by mi3_div, matrix_inverse_3x3, mi3_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;
	localparam int ORDER     = 3;
	localparam int LANES     = ORDER * ORDER;
	localparam int EW        = 16;  // Q8.8 element
	localparam int PW        = 32;  // element product
	localparam int CW        = 33;  // cofactor, Q16.16
	localparam int TW        = 49;  // element times cofactor
	localparam int DW        = 50;  // determinant, Q24.24
	localparam int NUM_SHIFT = 24;  // numerator scale
	localparam int QBITS     = 33;  // quotient bits formed by the divider
	localparam int OW        = 32;  // Q16.16 result

	typedef struct packed {
		logic signed [EW-1:0] a00;
		logic signed [EW-1:0] a01;
		logic signed [EW-1:0] a02;
		logic signed [EW-1:0] a10;
		logic signed [EW-1:0] a11;
		logic signed [EW-1:0] a12;
		logic signed [EW-1:0] a20;
		logic signed [EW-1:0] a21;
		logic signed [EW-1:0] a22;
	} mat_t;

	typedef struct packed {
		logic signed [OW-1:0] inv00;
		logic signed [OW-1:0] inv01;
		logic signed [OW-1:0] inv02;
		logic signed [OW-1:0] inv10;
		logic signed [OW-1:0] inv11;
		logic signed [OW-1:0] inv12;
		logic signed [OW-1:0] inv20;
		logic signed [OW-1:0] inv21;
		logic signed [OW-1:0] inv22;
		logic                 singular;
	} res_t;
endpackage
`default_nettype wire

// ----- src/mi3_div.sv -----
// One divider lane: pipelined restoring division, one quotient bit per stage.
// Computes (num << NUM_SHIFT) / den on magnitudes; depends on mi3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mi3_div (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [mi3_pkg::CW-1:0]    num,
	input  wire logic [mi3_pkg::DW-1:0]    den,
	output logic      [mi3_pkg::QBITS-1:0] quo,
	output logic                           ovf
);
	localparam int QB  = mi3_pkg::QBITS;
	localparam int DW  = mi3_pkg::DW;
	localparam int CW  = mi3_pkg::CW;
	localparam int SH  = mi3_pkg::NUM_SHIFT;
	localparam int TOP = CW + SH - QB;  // bits of num above the quotient window

	logic [DW-1:0] rem_s [QB+1];
	logic [QB-1:0] low_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic          ovf_s [QB+1];

	// The scaled numerator's top part must stay below den, else the quotient overflows.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(num[CW-1:CW-TOP]);
			low_s[0] <= {num[CW-TOP-1:0], SH'(0)};
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= (DW'(num[CW-1:CW-TOP]) >= den);
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [DW:0] trial;
		assign trial = {rem_s[k-1], low_s[k-1][QB-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= {1'b0, den_s[k-1]}) begin
					rem_s[k] <= DW'(trial - {1'b0, den_s[k-1]});
					quo_s[k] <= {quo_s[k-1][QB-2:0], 1'b1};
				end else begin
					rem_s[k] <= trial[DW-1:0];
					quo_s[k] <= {quo_s[k-1][QB-2:0], 1'b0};
				end
				low_s[k] <= {low_s[k-1][QB-2:0], 1'b0};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];
endmodule
`default_nettype wire

// ----- src/matrix_inverse_3x3.sv -----
// Top level of the 3x3 fixed-point matrix inverse by the adjugate.
// Depends on mi3_pkg and mi3_div (nine divider lanes).
`timescale 1ns / 1ps
`default_nettype none
// Takes one 3x3 matrix of signed Q8.8 elements per transaction and returns its inverse as
// nine signed Q16.16 values, truncated toward zero and saturated to 32 bits, plus a singular
// flag; a zero determinant gives singular = 1 and all-zero elements. The block accepts one
// matrix every cycle while the output side keeps up. Between acceptance and the result,
// four stages form the products, cofactors and determinant, 34 stages form the quotients in
// nine restoring divider lanes (an input stage, then one quotient bit per stage), and one
// output register holds the result. The whole pipeline advances together and holds while a
// waiting result is stalled, so a stall drops or repeats nothing.
module matrix_inverse_3x3 (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          mat_valid,
	output logic               mat_stall,
	input  wire mi3_pkg::mat_t mat,
	output logic               inv_valid,
	input  wire logic          inv_stall,
	output mi3_pkg::res_t      inv
);
	localparam int N  = mi3_pkg::ORDER;
	localparam int L  = mi3_pkg::LANES;
	localparam int EW = mi3_pkg::EW;
	localparam int PW = mi3_pkg::PW;
	localparam int CW = mi3_pkg::CW;
	localparam int TW = mi3_pkg::TW;
	localparam int DW = mi3_pkg::DW;
	localparam int QB = mi3_pkg::QBITS;
	localparam int OW = mi3_pkg::OW;
	localparam int DL = QB + 1;  // divider latency

	logic adv;
	logic inv_valid_q;
	mi3_pkg::res_t inv_q;

	// Advance everything unless a finished result is waiting on a stalled consumer.
	assign adv       = !(inv_valid_q && inv_stall);
	assign mat_stall = !adv;

	logic signed [EW-1:0] a [N][N];
	assign a[0][0] = mat.a00; assign a[0][1] = mat.a01; assign a[0][2] = mat.a02;
	assign a[1][0] = mat.a10; assign a[1][1] = mat.a11; assign a[1][2] = mat.a12;
	assign a[2][0] = mat.a20; assign a[2][1] = mat.a21; assign a[2][2] = mat.a22;

	logic signed [PW-1:0] pa_s1 [N][N];
	logic signed [PW-1:0] pb_s1 [N][N];
	logic signed [CW-1:0] cof_s2 [N][N];
	logic signed [CW-1:0] cof_s3 [N][N];
	logic signed [CW-1:0] cof_s4 [N][N];
	logic signed [EW-1:0] a0_s1 [N];
	logic signed [EW-1:0] a0_s2 [N];
	logic signed [TW-1:0] dp_s3 [N];
	logic signed [DW-1:0] det_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// Stage 1: the two products of every 2x2 minor, with cyclic row and column picks.
	for (genvar i = 0; i < N; i++) begin : g_row
		for (genvar j = 0; j < N; j++) begin : g_col
			localparam int R1 = (i + 1) % N;
			localparam int R2 = (i + 2) % N;
			localparam int C1 = (j + 1) % N;
			localparam int C2 = (j + 2) % N;
			always_ff @(posedge clk) begin
				if (adv) begin
					pa_s1[i][j]  <= a[R1][C1] * a[R2][C2];
					pb_s1[i][j]  <= a[R1][C2] * a[R2][C1];
					// Stage 2: cofactor, exact in 33 bits.
					cof_s2[i][j] <= {pa_s1[i][j][PW-1], pa_s1[i][j]}
						- {pb_s1[i][j][PW-1], pb_s1[i][j]};
					cof_s3[i][j] <= cof_s2[i][j];
					cof_s4[i][j] <= cof_s3[i][j];
				end
			end
		end
	end

	// Stages 3 and 4: expand the determinant along row 0.
	for (genvar j = 0; j < N; j++) begin : g_det
		always_ff @(posedge clk) begin
			if (adv) begin
				a0_s1[j] <= a[0][j];
				a0_s2[j] <= a0_s1[j];
				dp_s3[j] <= a0_s2[j] * cof_s2[0][j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= DW'(dp_s3[0]) + DW'(dp_s3[1]) + DW'(dp_s3[2]);
		end
	end

	// Divider lanes, one per cofactor; sign and singular flag ride alongside.
	logic [DW-1:0] den_mag;
	logic          det_zero;
	assign den_mag  = det_s4[DW-1] ? DW'(-det_s4) : DW'(det_s4);
	assign det_zero = (det_s4 == '0);

	logic [L-1:0] neg_d [DL];
	logic         sing_d [DL];
	logic         vld_d [DL];
	logic [QB-1:0] quo [L];
	logic [L-1:0]  ovf;
	logic [OW-1:0] val [L];

	for (genvar i = 0; i < N; i++) begin : g_lrow
		for (genvar j = 0; j < N; j++) begin : g_lcol
			localparam int K = i * N + j;
			logic [CW-1:0] num_mag;
			assign num_mag = cof_s4[i][j][CW-1] ? CW'(-cof_s4[i][j]) : CW'(cof_s4[i][j]);
			always_ff @(posedge clk) begin
				if (adv) begin
					neg_d[0][K] <= cof_s4[i][j][CW-1] ^ det_s4[DW-1];
				end
			end
			mi3_div u_div (
				.clk (clk),
				.en  (adv),
				.num (num_mag),
				.den (den_mag),
				.quo (quo[K]),
				.ovf (ovf[K])
			);
			// Saturate to Q16.16, then apply the sign; singular forces zero.
			always_comb begin
				priority if (sing_d[DL-1]) begin
					val[K] = '0;
				end else if (!neg_d[DL-1][K]) begin
					if (ovf[K] || quo[K][QB-1:OW-1] != '0) val[K] = {1'b0, {(OW-1){1'b1}}};
					else                                    val[K] = quo[K][OW-1:0];
				end else begin
					if (ovf[K] || quo[K] > QB'({1'b1, (OW-1)'(0)}))
						val[K] = {1'b1, (OW-1)'(0)};
					else
						val[K] = OW'(-quo[K][OW-1:0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_d[0] <= det_zero;
		end
	end

	for (genvar k = 1; k < DL; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_d[k]  <= neg_d[k-1];
				sing_d[k] <= sing_d[k-1];
			end
		end
	end

	// Valid bits travel with the data; hold on stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			for (int k = 0; k < DL; k++) vld_d[k] <= 1'b0;
			inv_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1   <= mat_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_d[0] <= vld_s4;
			for (int k = 1; k < DL; k++) vld_d[k] <= vld_d[k-1];
			inv_valid_q <= vld_d[DL-1];
		end
	end

	// Output register; lane (i,j) holds cofactor (i,j), which lands at inverse (j,i).
	always_ff @(posedge clk) begin
		if (adv) begin
			inv_q.inv00    <= val[0];
			inv_q.inv10    <= val[1];
			inv_q.inv20    <= val[2];
			inv_q.inv01    <= val[3];
			inv_q.inv11    <= val[4];
			inv_q.inv21    <= val[5];
			inv_q.inv02    <= val[6];
			inv_q.inv12    <= val[7];
			inv_q.inv22    <= val[8];
			inv_q.singular <= sing_d[DL-1];
		end
	end

	assign inv_valid = inv_valid_q;
	assign inv       = inv_q;

	// A singular result carries all-zero elements.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid_q && inv_q.singular |->
			inv_q.inv00 == '0 && inv_q.inv01 == '0 && inv_q.inv02 == '0 &&
			inv_q.inv10 == '0 && inv_q.inv11 == '0 && inv_q.inv12 == '0 &&
			inv_q.inv20 == '0 && inv_q.inv21 == '0 && inv_q.inv22 == '0)
		else $error("singular result with nonzero element");

	// A zero determinant enters the divider side band flagged singular.
	a_det_flag: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && adv && det_s4 == '0 |=> sing_d[0] && vld_d[0])
		else $error("zero determinant not flagged");

	// Valid moves one stage per advance and never moves while held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_d[0]) && $stable(vld_s4) && $stable(inv_valid_q))
		else $error("pipeline moved during stall");
endmodule
`default_nettype wire

// ----- dv/mi3_checker.sv -----
// Checker for the 3x3 fixed-point matrix inverse: predicts each inverse and compares.
// Depends on mi3_pkg; watches the mat and inv channels of matrix_inverse_3x3.
`timescale 1ns / 1ps
`default_nettype none
module mi3_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          mat_valid,
	input  wire logic          mat_stall,
	input  wire mi3_pkg::mat_t mat,
	input  wire logic          inv_valid,
	input  wire logic          inv_stall,
	input  wire mi3_pkg::res_t inv,
	output int                 fail_count,
	output int                 pending
);
	mi3_pkg::res_t expected_inverses[$];

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic mi3_pkg::res_t invert(mi3_pkg::mat_t m);
		longint e[3][3];
		longint cof[3][3];
		longint det;
		longint q;
		logic [mi3_pkg::OW-1:0] lane[9];
		mi3_pkg::res_t r;
		e[0][0] = m.a00; e[0][1] = m.a01; e[0][2] = m.a02;
		e[1][0] = m.a10; e[1][1] = m.a11; e[1][2] = m.a12;
		e[2][0] = m.a20; e[2][1] = m.a21; e[2][2] = m.a22;
		det = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				cof[i][j] = e[(i+1)%3][(j+1)%3] * e[(i+2)%3][(j+2)%3]
					- e[(i+1)%3][(j+2)%3] * e[(i+2)%3][(j+1)%3];
			end
		end
		for (int j = 0; j < 3; j++) det += e[0][j] * cof[0][j];
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		// transpose the cofactors; SV division truncates toward zero
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				q = sat32((cof[i][j] <<< mi3_pkg::NUM_SHIFT) / det);
				lane[j*3+i] = q[mi3_pkg::OW-1:0];
			end
		end
		r.inv00 = lane[0]; r.inv01 = lane[1]; r.inv02 = lane[2];
		r.inv10 = lane[3]; r.inv11 = lane[4]; r.inv12 = lane[5];
		r.inv20 = lane[6]; r.inv21 = lane[7]; r.inv22 = lane[8];
		return r;
	endfunction

	task automatic report(string what, mi3_pkg::res_t exp_r, mi3_pkg::res_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("MISMATCH %s: expected %p, got %p", what, exp_r, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		mi3_pkg::res_t exp_r;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (mat_valid && !mat_stall) expected_inverses.push_back(invert(mat));
			if (inv_valid && !inv_stall) begin
				if (expected_inverses.size() == 0) begin
					report("unexpected result", '0, inv);
				end else begin
					exp_r = expected_inverses.pop_front();
					if (exp_r !== inv) report("inverse", exp_r, inv);
				end
			end
			pending <= expected_inverses.size();
		end
	end
endmodule
`default_nettype wire

// ----- dv/tb_matrix_inverse_3x3.sv -----
// Testbench top for matrix_inverse_3x3: drives matrices, stalls results, gives the verdict.
// Depends on mi3_pkg, matrix_inverse_3x3 and mi3_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_matrix_inverse_3x3;
	localparam int LATENCY = 39;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_MATS = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_stall;
	mi3_pkg::mat_t mat = '0;
	logic inv_valid;
	logic inv_stall = 1'b0;
	mi3_pkg::res_t inv;
	int fail_count;
	int pending;
	int idle_cycles;
	logic steady;  // no idling on either side while high

	always #10 clk = ~clk;

	matrix_inverse_3x3 dut (.*);

	mi3_checker checker_i (.*);

	// random stalls on the result side, suppressed during the steady stretch
	always @(negedge clk) begin
		inv_stall <= steady ? 1'b0 : ($urandom_range(99) < 27);
	end

	// watchdog: count cycles with no accepted transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (mat_valid && !mat_stall) || (inv_valid && !inv_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic logic signed [mi3_pkg::EW-1:0] pick_elem();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			3: return 16'sh0100;
			4: return 16'shff00;
			5: return $signed(16'($urandom_range(1023)) - 16'd512);
			default: return $signed(16'($urandom()));
		endcase
	endfunction

	function automatic mi3_pkg::mat_t random_mat();
		mi3_pkg::mat_t m;
		int kind;
		kind = $urandom_range(9);
		m.a00 = pick_elem(); m.a01 = pick_elem(); m.a02 = pick_elem();
		m.a10 = pick_elem(); m.a11 = pick_elem(); m.a12 = pick_elem();
		m.a20 = pick_elem(); m.a21 = pick_elem(); m.a22 = pick_elem();
		// make singular now and then: duplicate a row, or zero a column
		if (kind == 0) begin
			m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
		end else if (kind == 1) begin
			m.a01 = '0; m.a11 = '0; m.a21 = '0;
		end
		return m;
	endfunction

	// present one matrix, hold it until accepted, then maybe idle
	task automatic send(mi3_pkg::mat_t m);
		mat <= m;
		mat_valid <= 1'b1;
		do @(posedge clk); while (mat_stall);
		@(negedge clk);
		if (!steady && $urandom_range(99) < 27) begin
			mat_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 40);
		end
	endtask

	task automatic drain();
		mat_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	initial begin
		mi3_pkg::mat_t m;
		steady = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: identity, scaled identity, extremes, singular cases, overflow
		m = '0; m.a00 = 16'sh0100; m.a11 = 16'sh0100; m.a22 = 16'sh0100; send(m);
		m = '0; m.a00 = 16'sh0200; m.a11 = 16'shfe00; m.a22 = 16'sh0080; send(m);
		send('0);
		m = {9{16'sh7fff}}; send(m);
		m = {9{16'sh8000}}; send(m);
		m = '0; m.a00 = 16'sh0001; m.a11 = 16'sh0001; m.a22 = 16'sh0001; send(m);
		m = '0; m.a00 = 16'sh7fff; m.a11 = 16'sh7fff; m.a22 = 16'sh7fff; send(m);
		m = '0; m.a00 = 16'sh8000; m.a11 = 16'sh8000; m.a22 = 16'sh8000; send(m);
		m = '0; m.a02 = 16'sh0100; m.a11 = 16'sh0100; m.a20 = 16'sh0100; send(m);
		m = '0; m.a00 = 16'sh7fff; m.a01 = 16'sh8000; m.a02 = 16'sh0001;
		m.a10 = 16'sh8000; m.a11 = 16'sh7fff; m.a12 = 16'sh0001;
		m.a20 = 16'sh0001; m.a21 = 16'sh0001; m.a22 = 16'sh8000; send(m);
		m = '0; m.a00 = 16'sh0001; m.a11 = 16'sh7fff; m.a22 = 16'sh8000; send(m);
		m = '0; m.a00 = 16'sh0100; m.a01 = 16'sh0200; m.a02 = 16'sh0300;
		m.a10 = 16'sh0400; m.a11 = 16'sh0500; m.a12 = 16'sh0600;
		m.a20 = 16'sh0700; m.a21 = 16'sh0800; m.a22 = 16'sh0900; send(m);
		m = '0; m.a00 = 16'sh5555; m.a11 = 16'shaaaa; m.a22 = 16'sh5555;
		m.a01 = 16'shaaaa; send(m);

		// pause until every expected inverse has arrived
		drain();

		for (int k = 0; k < RANDOM_MATS; k++) begin
			// a long stretch with no idling on either side
			steady = (k >= 300 && k < 450);
			send(random_mat());
		end
		steady = 1'b0;
		drain();

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire
